/* hw/rtl/mbrpt_pkg.sv */
// Shared constants and types for the MBR partition table parser.
// Used by mbrpt_fit_chk and mbr_partition_table_parser; depends on nothing.
`default_nettype none

package mbrpt_pkg;

    // Sector layout
    localparam int SECTOR_BYTES  = 512;
    localparam int POS_W         = $clog2(SECTOR_BYTES);
    localparam int TABLE_ENTRIES = 4;
    localparam int ENTRY_W       = $clog2(TABLE_ENTRIES);
    localparam int TBL_BASE      = 446;
    localparam int ENT_BYTES     = 16;
    localparam int TBL_END       = TBL_BASE + ENT_BYTES * TABLE_ENTRIES;
    localparam int REL_W         = $clog2(ENT_BYTES * TABLE_ENTRIES);
    localparam int OFF_W         = $clog2(ENT_BYTES);

    // Offsets inside one table entry
    localparam logic [OFF_W-1:0] OFF_STATUS = 4'd0;
    localparam logic [OFF_W-1:0] OFF_TYPE   = 4'd4;
    localparam logic [1:0]       LANE_START = 2'd2;
    localparam logic [1:0]       LANE_COUNT = 2'd3;

    // FAT parameter bytes: offsets 11..16 go to slots 0..5, offset 21 to slot 6
    localparam int BPB_FIRST  = 11;
    localparam int BPB_LAST   = 16;
    localparam int MEDIA_POS  = 21;
    localparam int BPB_SLOTS  = 7;
    localparam int BPB_IDX_W  = $clog2(BPB_SLOTS);
    localparam logic [BPB_IDX_W-1:0] MEDIA_SLOT = 3'd6;
    localparam int SIG_POS    = 510;

    // Byte codes
    localparam logic [7:0] SIG_BYTE0       = 8'h55;
    localparam logic [7:0] SIG_BYTE1       = 8'hAA;
    localparam logic [7:0] STATUS_IDLE     = 8'h00;
    localparam logic [7:0] STATUS_BOOTABLE = 8'h80;
    localparam logic [7:0] TYPE_EMPTY      = 8'h00;
    localparam logic [7:0] TYPE_EXT_CHS    = 8'h05;
    localparam logic [7:0] TYPE_EXT_LBA    = 8'h0F;
    localparam logic [7:0] TYPE_EXT_LNX    = 8'h85;
    localparam logic [7:0] MEDIA_F0        = 8'hF0;
    localparam logic [7:0] MEDIA_F8        = 8'hF8;
    localparam logic [15:0] FAT_BPS        = 16'd512;

    // Digit-serial sector arithmetic
    localparam int LBA_W   = 32;
    localparam int DIGIT_W = 8;
    localparam int DIGITS  = LBA_W / DIGIT_W;
    localparam int DCNT_W  = $clog2(DIGITS);

    // Status of the fit checker as seen by the sequencer
    typedef struct packed {
        logic done;  // one-cycle pulse after the last digit
        logic fits;  // start and count are nonzero and lie inside the disk
    } fit_res_t;

endpackage

`default_nettype wire

/* hw/rtl/mbrpt_fit_chk.sv */
// Digit-serial bounds check of one partition entry against the disk size.
// Depends on mbrpt_pkg.
`default_nettype none

module mbrpt_fit_chk (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      load,
    input  wire logic [mbrpt_pkg::LBA_W-1:0] start_sector,
    input  wire logic [mbrpt_pkg::LBA_W-1:0] sector_count,
    input  wire logic [mbrpt_pkg::LBA_W-1:0] disk_sectors,
    output mbrpt_pkg::fit_res_t            res
);

    localparam int W  = mbrpt_pkg::LBA_W;
    localparam int DW = mbrpt_pkg::DIGIT_W;

    logic [W-1:0]                    st_sh_reg;
    logic [W-1:0]                    ct_sh_reg;
    logic [W-1:0]                    dk_sh_reg;
    logic [mbrpt_pkg::DCNT_W-1:0]    cnt_reg;
    logic                            busy_reg;
    logic                            done_reg;
    logic                            borrow_reg;
    logic                            diff_nz_reg;
    logic                            st_nz_reg;
    logic                            ct_nz_reg;
    logic                            ct_le_reg;

    logic [DW:0]   sub;
    logic [DW-1:0] diff_digit;
    logic [DW-1:0] st_digit;
    logic [DW-1:0] ct_digit;
    logic          ct_le_next;

    // One digit of disk - start per cycle, least significant first.
    assign st_digit   = st_sh_reg[DW-1:0];
    assign ct_digit   = ct_sh_reg[DW-1:0];
    assign sub        = {1'b0, dk_sh_reg[DW-1:0]} - {1'b0, st_digit} - {{DW{1'b0}}, borrow_reg};
    assign diff_digit = sub[DW-1:0];
    // Going upward, a higher digit decides; an equal digit keeps the lower verdict.
    assign ct_le_next = (ct_digit < diff_digit) || ((ct_digit == diff_digit) && ct_le_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
            borrow_reg  <= 1'b0;
            diff_nz_reg <= 1'b0;
            st_nz_reg   <= 1'b0;
            ct_nz_reg   <= 1'b0;
            ct_le_reg   <= 1'b1;
        end
        else
        begin
            done_reg <= 1'b0;
            if (load)
            begin
                busy_reg    <= 1'b1;
                cnt_reg     <= '0;
                borrow_reg  <= 1'b0;
                diff_nz_reg <= 1'b0;
                st_nz_reg   <= 1'b0;
                ct_nz_reg   <= 1'b0;
                ct_le_reg   <= 1'b1;
            end
            else if (busy_reg)
            begin
                borrow_reg  <= sub[DW];
                diff_nz_reg <= diff_nz_reg || (diff_digit != '0);
                st_nz_reg   <= st_nz_reg || (st_digit != '0);
                ct_nz_reg   <= ct_nz_reg || (ct_digit != '0);
                ct_le_reg   <= ct_le_next;
                cnt_reg     <= cnt_reg + 1'b1;
                if (cnt_reg == mbrpt_pkg::DCNT_W'(mbrpt_pkg::DIGITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            st_sh_reg <= start_sector;
            ct_sh_reg <= sector_count;
            dk_sh_reg <= disk_sectors;
        end
        else if (busy_reg)
        begin
            st_sh_reg <= {{DW{1'b0}}, st_sh_reg[W-1:DW]};
            ct_sh_reg <= {{DW{1'b0}}, ct_sh_reg[W-1:DW]};
            dk_sh_reg <= {{DW{1'b0}}, dk_sh_reg[W-1:DW]};
        end
    end

    // start < disk when the subtraction neither borrows nor comes out zero.
    assign res.done = done_reg;
    assign res.fits = st_nz_reg && ct_nz_reg && !borrow_reg && diff_nz_reg && ct_le_reg;

endmodule

`default_nettype wire

/* hw/rtl/mbr_partition_table_parser.sv */
// Top level of the MBR partition table parser: byte capture, MBR test and result sequencing.
// Depends on mbrpt_pkg and mbrpt_fit_chk.
`default_nettype none

// Takes a 512-byte boot sector one byte per beat and, after the last byte, returns four
// result beats, one per partition table entry, with the entry's type, start, count, the
// MBR verdict for the sector and whether the entry is usable on a disk of the configured
// size. Bytes are taken one per cycle while byte_stall is low. Each entry is then checked
// against the disk size by a byte-serial subtract and compare: a load state, the digit
// steps, least significant first, a wait for the done pulse and a move of the result into
// the output register, which waits while the output is stalled. Meanwhile bytes of the next sector
// keep flowing; only a byte at offset 446 or above is held off until the burst is out.
// The byte position is a free-running counter from reset; there is no framing input.
// The disk size may be written whenever no result burst is under way.
module mbr_partition_table_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // sector byte channel
    input  wire logic        byte_valid,
    output logic             byte_stall,
    input  wire logic [7:0]  data_byte,
    // disk size register write
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data,
    // result channel
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [1:0]       entry_index,
    output logic [7:0]       partition_type,
    output logic [31:0]      first_sector,
    output logic [31:0]      sector_count,
    output logic             entry_usable,
    output logic             sector_is_mbr,
    output logic             last_entry
);

    localparam int POS_W = mbrpt_pkg::POS_W;
    localparam int NE    = mbrpt_pkg::TABLE_ENTRIES;
    localparam int EW    = mbrpt_pkg::ENTRY_W;
    localparam int LW    = mbrpt_pkg::LBA_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOAD = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_PUT  = 2'd3;

    logic [POS_W-1:0] pos_reg;
    logic             status_ok_reg;
    logic [7:0]       sig_reg;
    logic [7:0]       bparam_reg [mbrpt_pkg::BPB_SLOTS];
    logic [7:0]       types_reg  [NE];
    logic [LW-1:0]    starts_reg [NE];
    logic [LW-1:0]    counts_reg [NE];
    logic [LW-1:0]    disk_reg;
    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [EW-1:0]    eidx_reg;
    logic [EW-1:0]    eidx_next;
    logic             mbr_reg;

    logic             result_valid_reg;
    logic [EW-1:0]    entry_index_reg;
    logic [7:0]       partition_type_reg;
    logic [LW-1:0]    first_sector_reg;
    logic [LW-1:0]    sector_count_reg;
    logic             entry_usable_reg;
    logic             sector_is_mbr_reg;
    logic             last_entry_reg;

    logic                        byte_acc;
    logic                        tbl_hit;
    logic [mbrpt_pkg::REL_W-1:0] rel;
    logic [EW-1:0]               ent;
    logic [mbrpt_pkg::OFF_W-1:0] off;
    logic                        bpb_hit;
    logic [mbrpt_pkg::BPB_IDX_W-1:0] bpb_idx;
    logic                        last_byte;
    logic                        status_byte_ok;
    logic                        fat_present;
    logic [15:0]                 bps;
    logic [7:0]                  spc;
    logic [15:0]                 rsv;
    logic [7:0]                  nfats;
    logic [7:0]                  media;
    logic                        mbr_now;
    logic                        slot_free;
    logic                        type_ok;
    logic [7:0]                  cur_type;
    mbrpt_pkg::fit_res_t         chk_res;

    // ---------------------------------------------------------------- input side
    assign byte_stall = (state_reg != S_IDLE) && (pos_reg >= POS_W'(mbrpt_pkg::TBL_BASE));
    assign byte_acc   = byte_valid && !byte_stall;
    assign cfg_ready  = 1'b1;

    assign tbl_hit = (pos_reg >= POS_W'(mbrpt_pkg::TBL_BASE))
                  && (pos_reg <  POS_W'(mbrpt_pkg::TBL_END));
    assign rel     = mbrpt_pkg::REL_W'(pos_reg - POS_W'(mbrpt_pkg::TBL_BASE));
    assign ent     = rel[mbrpt_pkg::REL_W-1:mbrpt_pkg::OFF_W];
    assign off     = rel[mbrpt_pkg::OFF_W-1:0];
    assign bpb_hit = (pos_reg >= POS_W'(mbrpt_pkg::BPB_FIRST))
                  && (pos_reg <= POS_W'(mbrpt_pkg::BPB_LAST));
    assign bpb_idx = mbrpt_pkg::BPB_IDX_W'(pos_reg - POS_W'(mbrpt_pkg::BPB_FIRST));
    assign last_byte = (pos_reg == POS_W'(mbrpt_pkg::SECTOR_BYTES - 1));

    assign status_byte_ok = (data_byte == mbrpt_pkg::STATUS_IDLE)
                         || (data_byte == mbrpt_pkg::STATUS_BOOTABLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            status_ok_reg <= 1'b1;
            disk_reg      <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                disk_reg <= cfg_data;
            end
            if (byte_acc)
            begin
                pos_reg <= pos_reg + 1'b1;
                if (pos_reg == '0)
                begin
                    status_ok_reg <= 1'b1;
                end
                else if (tbl_hit && (off == mbrpt_pkg::OFF_STATUS) && !status_byte_ok)
                begin
                    status_ok_reg <= 1'b0;
                end
            end
        end
    end

    // Captured sector bytes; no reset, every one is written before it is read.
    always_ff @(posedge clk)
    begin
        if (byte_acc)
        begin
            if (bpb_hit)
            begin
                bparam_reg[bpb_idx] <= data_byte;
            end
            else if (pos_reg == POS_W'(mbrpt_pkg::MEDIA_POS))
            begin
                bparam_reg[mbrpt_pkg::MEDIA_SLOT] <= data_byte;
            end
            if (pos_reg == POS_W'(mbrpt_pkg::SIG_POS))
            begin
                sig_reg <= data_byte;
            end
            if (tbl_hit)
            begin
                if (off == mbrpt_pkg::OFF_TYPE)
                begin
                    types_reg[ent] <= data_byte;
                end
                else if (off[3:2] == mbrpt_pkg::LANE_START)
                begin
                    starts_reg[ent][{off[1:0], 3'b000} +: 8] <= data_byte;
                end
                else if (off[3:2] == mbrpt_pkg::LANE_COUNT)
                begin
                    counts_reg[ent][{off[1:0], 3'b000} +: 8] <= data_byte;
                end
            end
        end
    end

    // ---------------------------------------------------------------- MBR test
    assign bps   = {bparam_reg[1], bparam_reg[0]};
    assign spc   = bparam_reg[2];
    assign rsv   = {bparam_reg[4], bparam_reg[3]};
    assign nfats = bparam_reg[5];
    assign media = bparam_reg[mbrpt_pkg::MEDIA_SLOT];

    assign fat_present = (bps == mbrpt_pkg::FAT_BPS)
                      && (spc != 8'd0) && ((spc & (spc - 8'd1)) == 8'd0)
                      && (rsv != 16'd0)
                      && ((nfats == 8'd1) || (nfats == 8'd2))
                      && ((media == mbrpt_pkg::MEDIA_F0) || (media >= mbrpt_pkg::MEDIA_F8));

    assign mbr_now = (sig_reg == mbrpt_pkg::SIG_BYTE0) && (data_byte == mbrpt_pkg::SIG_BYTE1)
                  && !fat_present && status_ok_reg;

    // ---------------------------------------------------------------- result sequencer
    assign slot_free = !result_valid_reg || !result_stall;

    always_comb
    begin
        state_next = state_reg;
        eidx_next  = eidx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (byte_acc && last_byte)
                begin
                    state_next = S_LOAD;
                    eidx_next  = '0;
                end
            end
            S_LOAD:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (chk_res.done)
                begin
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                if (slot_free)
                begin
                    if (eidx_reg == EW'(NE - 1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_LOAD;
                        eidx_next  = eidx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            eidx_reg         <= '0;
            mbr_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            eidx_reg  <= eidx_next;
            if ((state_reg == S_IDLE) && byte_acc && last_byte)
            begin
                mbr_reg <= mbr_now;
            end
            if ((state_reg == S_PUT) && slot_free)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    mbrpt_fit_chk u_fit_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (state_reg == S_LOAD),
        .start_sector (starts_reg[eidx_reg]),
        .sector_count (counts_reg[eidx_reg]),
        .disk_sectors (disk_reg),
        .res          (chk_res)
    );

    assign cur_type = types_reg[eidx_reg];
    assign type_ok  = (cur_type != mbrpt_pkg::TYPE_EMPTY)
                   && (cur_type != mbrpt_pkg::TYPE_EXT_CHS)
                   && (cur_type != mbrpt_pkg::TYPE_EXT_LBA)
                   && (cur_type != mbrpt_pkg::TYPE_EXT_LNX);

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_PUT) && slot_free)
        begin
            entry_index_reg    <= eidx_reg;
            partition_type_reg <= cur_type;
            first_sector_reg   <= starts_reg[eidx_reg];
            sector_count_reg   <= counts_reg[eidx_reg];
            entry_usable_reg   <= mbr_reg && type_ok && chk_res.fits;
            sector_is_mbr_reg  <= mbr_reg;
            last_entry_reg     <= (eidx_reg == EW'(NE - 1));
        end
    end

    assign result_valid   = result_valid_reg;
    assign entry_index    = entry_index_reg;
    assign partition_type = partition_type_reg;
    assign first_sector   = first_sector_reg;
    assign sector_count   = sector_count_reg;
    assign entry_usable   = entry_usable_reg;
    assign sector_is_mbr  = sector_is_mbr_reg;
    assign last_entry     = last_entry_reg;

    // ---------------------------------------------------------------- assertions
    a_burst_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_acc && last_byte) |=> ((state_reg == S_LOAD) && (eidx_reg == '0)))
        else $error("last sector byte did not start a result burst");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        chk_res.done |-> (state_reg == S_WAIT))
        else $error("fit checker finished outside the wait state");

    a_usable_needs_mbr: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (!entry_usable || sector_is_mbr))
        else $error("usable entry reported on a sector that is not an MBR");

    a_no_table_write_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !(byte_acc && tbl_hit))
        else $error("table byte taken while results are still being sent");

endmodule

`default_nettype wire
